@@ sv/max_heap_priority_queue_top_defines.svh @@
// Assertion macros for the heap priority queue
`ifndef MAX_HEAP_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define MAX_HEAP_PRIORITY_QUEUE_TOP_DEFINES_SVH
`ifndef SYNTH
`define MHPQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define MHPQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MHPQ_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MHPQ_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ sv/mhpq_pkg.sv @@
// Package: codes and constants of the heap priority queue
`default_nettype none
package mhpq_pkg;
  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned VAL_W = 32;
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;
endpackage
`default_nettype wire

@@ sv/max_heap_priority_queue_top.sv @@
// Top level: bounded binary max-heap priority queue held in one RAM
// One item at a time, from acceptance to the result leaving. Insert: write at the end, then
// climb while larger than the parent. Pop: move the last entry into the root, then sink it.
// Remove: as pop, after a linear search for the value; a refilled slot may climb instead.
// All heap traffic goes through the one RAM, which has a write port and a registered read
// port. The result is held in an output register; the next item is taken once it has gone.
`default_nettype none
`include "max_heap_priority_queue_top_defines.svh"
module max_heap_priority_queue_top #(
  parameter int unsigned CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_opcode,
  input  wire logic signed [31:0] in_value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              out_status,
  output logic signed [31:0]      out_removed_value,
  output logic signed [31:0]      out_top_value,
  output logic [6:0]              out_entry_count
);
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_UPRD  = 12'b000000000010,
    S_UPCMP = 12'b000000000100,
    S_SRCH  = 12'b000000001000,
    S_LAST  = 12'b000000010000,
    S_FIX   = 12'b000000100000,
    S_DNL   = 12'b000001000000,
    S_DNR   = 12'b000010000000,
    S_DNCMP = 12'b000100000000,
    S_TOP   = 12'b001000000000,
    S_TOPW  = 12'b010000000000,
    S_OUT   = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;
  logic signed [31:0] mem [CAPACITY];
  logic signed [31:0] rdata_r;
  logic               we;
  logic [AW-1:0]      waddr, raddr;
  logic signed [31:0] wdata;

  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [AW-1:0]      pos_r, pos_nxt, idx_r, idx_nxt;
  logic signed [31:0] cur_r, cur_nxt, best_r, best_nxt, val_r, val_nxt;
  logic [AW-1:0]      bidx_r, bidx_nxt;
  logic [1:0]         op_r, op_nxt, st_r, st_nxt;
  logic signed [31:0] rem_r, rem_nxt, top_r, top_nxt;
  logic               hasr_r, hasr_nxt;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  logic [AW:0] lft, rgt;
  logic [AW-1:0] par;
  assign lft = {pos_r, 1'b1};
  assign rgt = {pos_r, 1'b1} + 1'b1;
  assign par = (pos_r - 1'b1) >> 1;

  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r; pos_nxt = pos_r; idx_nxt = idx_r;
    cur_nxt = cur_r; best_nxt = best_r; bidx_nxt = bidx_r; val_nxt = val_r;
    op_nxt = op_r; st_nxt = st_r; rem_nxt = rem_r; top_nxt = top_r; hasr_nxt = hasr_r;
    we = 1'b0; waddr = pos_r; wdata = cur_r; raddr = '0;
    case (state_r)
      S_IDLE: if (in_valid) begin
        op_nxt = in_opcode; val_nxt = in_value; st_nxt = mhpq_pkg::ST_OK; rem_nxt = '0;
        state_nxt = S_TOP;
        if (in_opcode == mhpq_pkg::OP_INSERT) begin
          if (cnt_r >= CW'(CAPACITY)) st_nxt = mhpq_pkg::ST_FULL;
          else begin
            pos_nxt = AW'(cnt_r); cur_nxt = in_value; cnt_nxt = cnt_r + 1'b1;
            we = 1'b1; waddr = AW'(cnt_r); wdata = in_value;
            if (cnt_r != '0) begin
              raddr = AW'((AW'(cnt_r) - 1'b1) >> 1); state_nxt = S_UPCMP;
            end
          end
        end else if (in_opcode == mhpq_pkg::OP_POP || in_opcode == mhpq_pkg::OP_REMOVE) begin
          if (cnt_r == '0) st_nxt = mhpq_pkg::ST_EMPTY;
          else begin idx_nxt = '0; raddr = '0; state_nxt = S_SRCH; end
        end
      end
      S_UPCMP: begin
        if (cur_r > rdata_r) begin
          we = 1'b1; waddr = pos_r; wdata = rdata_r; pos_nxt = par;
          state_nxt = S_UPRD;
        end else state_nxt = S_TOP;
      end
      S_UPRD: begin
        we = 1'b1; waddr = pos_r; wdata = cur_r;
        if (pos_r != '0) begin raddr = par; state_nxt = S_UPCMP; end
        else state_nxt = S_TOP;
      end
      S_SRCH: begin
        if (op_r == mhpq_pkg::OP_POP || rdata_r == val_r) begin
          rem_nxt = rdata_r; pos_nxt = idx_r; cnt_nxt = cnt_r - 1'b1;
          raddr = AW'(cnt_r - 1'b1); state_nxt = S_LAST;
          if (idx_r == AW'(cnt_r - 1'b1)) state_nxt = S_TOP;
        end else if ({1'b0, idx_r} + 1'b1 >= (AW+1)'(cnt_r)) begin
          st_nxt = mhpq_pkg::ST_NOTFOUND; state_nxt = S_TOP;
        end else begin
          idx_nxt = idx_r + 1'b1; raddr = idx_r + 1'b1;
        end
      end
      S_LAST: begin
        cur_nxt = rdata_r; we = 1'b1; waddr = pos_r; wdata = rdata_r;
        raddr = par; state_nxt = S_FIX;
      end
      S_FIX: begin
        if (pos_r != '0 && cur_r > rdata_r) begin
          we = 1'b1; waddr = pos_r; wdata = rdata_r; pos_nxt = par; state_nxt = S_UPRD;
        end else if (lft < (AW+1)'(cnt_r)) begin
          raddr = AW'(lft); state_nxt = S_DNL;
        end else state_nxt = S_TOP;
      end
      S_DNL: begin
        best_nxt = cur_r; bidx_nxt = pos_r;
        if (rdata_r > cur_r) begin best_nxt = rdata_r; bidx_nxt = AW'(lft); end
        if (rgt < (AW+1)'(cnt_r)) begin raddr = AW'(rgt); state_nxt = S_DNR; end
        else state_nxt = S_DNCMP;
      end
      S_DNR: begin
        if (rdata_r > best_r) begin best_nxt = rdata_r; bidx_nxt = AW'(rgt); end
        state_nxt = S_DNCMP;
      end
      S_DNCMP: begin
        if (bidx_r == pos_r) state_nxt = S_TOP;
        else begin
          we = 1'b1; waddr = pos_r; wdata = best_r; pos_nxt = bidx_r;
          state_nxt = S_TOPW;
        end
      end
      S_TOPW: begin
        we = 1'b1; waddr = pos_r; wdata = cur_r;
        if ({pos_r, 1'b1} < (AW+1)'(cnt_r)) begin
          raddr = AW'({pos_r, 1'b1}); state_nxt = S_DNL;
        end else state_nxt = S_TOP;
      end
      S_TOP: begin raddr = '0; hasr_nxt = 1'b1; state_nxt = S_OUT; end
      S_OUT: begin
        if (hasr_r) begin
          top_nxt = (cnt_r == '0) ? '0 : rdata_r; hasr_nxt = 1'b0;
        end else if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; cnt_r <= '0; hasr_r <= 1'b0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; hasr_r <= hasr_nxt;
    end
    pos_r <= pos_nxt; idx_r <= idx_nxt; cur_r <= cur_nxt; best_r <= best_nxt;
    bidx_r <= bidx_nxt; val_r <= val_nxt; op_r <= op_nxt; st_r <= st_nxt;
    rem_r <= rem_nxt; top_r <= top_nxt;
  end

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT) && !hasr_r;
  assign out_status = st_r;
  assign out_removed_value = rem_r;
  assign out_top_value = top_r;
  assign out_entry_count = 7'(cnt_r);

  `MHPQ_ASSERT_IMP(a_cnt_cap, clk, rst_n, 1'b1, cnt_r <= CW'(CAPACITY))
  `MHPQ_ASSERT_IMP(a_empty_top, clk, rst_n, out_valid && cnt_r == '0, out_top_value == '0)
  `MHPQ_ASSERT_NXT(a_take, clk, rst_n, in_valid && !in_stall, !out_valid)
endmodule
`default_nettype wire

@@ test/testbench.sv @@
// Testbench for the bounded max-heap priority queue: directed table, fill and drain, then random traffic
`timescale 1ns / 1ps
module testbench;
  localparam int CAP = int'(mhpq_pkg::CAPACITY_DEF);
  localparam logic [1:0] OP_NOP = 2'd3;
  localparam int LIMIT = 1500000;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] removed;
    logic signed [31:0] top;
    logic [6:0]         count;
  } heap_result_t;

  typedef struct {
    logic [1:0]         op;
    logic signed [31:0] val;
    bit                 fixed;
    heap_result_t       res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_opcode = '0;
  logic signed [31:0] in_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_status;
  logic signed [31:0] out_removed_value;
  logic signed [31:0] out_top_value;
  logic [6:0] out_entry_count;

  max_heap_priority_queue_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_opcode(in_opcode), .in_value(in_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_removed_value(out_removed_value),
    .out_top_value(out_top_value), .out_entry_count(out_entry_count)
  );

  always #6 clk = ~clk;

  logic signed [31:0] heap_mdl [CAP];
  int heap_len;
  heap_result_t expected_q[$];
  int errors = 0;
  int cycles = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_full = 0;
  int n_notfound = 0;

  task automatic report(input string what, input logic signed [31:0] got,
                        input logic signed [31:0] want);
    $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, n_checked);
    errors++;
  endtask

  function automatic void swap_nodes(input int a, input int b);
    logic signed [31:0] t;
    t = heap_mdl[a];
    heap_mdl[a] = heap_mdl[b];
    heap_mdl[b] = t;
  endfunction

  function automatic void climb(input int p);
    int par;
    while (p > 0) begin
      par = (p - 1) / 2;
      if (heap_mdl[p] <= heap_mdl[par]) break;
      swap_nodes(p, par);
      p = par;
    end
  endfunction

  function automatic void sink(input int p);
    int l, r, b;
    forever begin
      l = 2 * p + 1;
      r = l + 1;
      b = p;
      if (l < heap_len && heap_mdl[l] > heap_mdl[b]) b = l;
      if (r < heap_len && heap_mdl[r] > heap_mdl[b]) b = r;
      if (b == p) break;
      swap_nodes(p, b);
      p = b;
    end
  endfunction

  function automatic logic signed [31:0] extract_at(input int p);
    logic signed [31:0] v;
    v = heap_mdl[p];
    heap_len--;
    if (p != heap_len) begin
      heap_mdl[p] = heap_mdl[heap_len];
      if (p > 0 && heap_mdl[p] > heap_mdl[(p - 1) / 2]) climb(p);
      else sink(p);
    end
    return v;
  endfunction

  function automatic heap_result_t heap_apply(input logic [1:0] op,
                                              input logic signed [31:0] v);
    heap_result_t r;
    r = '0;
    r.status = mhpq_pkg::ST_OK;
    case (op)
      mhpq_pkg::OP_INSERT: begin
        if (heap_len >= CAP) r.status = mhpq_pkg::ST_FULL;
        else begin
          heap_mdl[heap_len] = v;
          heap_len++;
          climb(heap_len - 1);
        end
      end
      mhpq_pkg::OP_POP: begin
        if (heap_len == 0) r.status = mhpq_pkg::ST_EMPTY;
        else r.removed = extract_at(0);
      end
      mhpq_pkg::OP_REMOVE: begin
        if (heap_len == 0) r.status = mhpq_pkg::ST_EMPTY;
        else begin
          r.status = mhpq_pkg::ST_NOTFOUND;
          for (int i = 0; i < heap_len; i++) begin
            if (heap_mdl[i] == v) begin
              r.removed = extract_at(i);
              r.status = mhpq_pkg::ST_OK;
              break;
            end
          end
        end
      end
      default: ;
    endcase
    r.top = heap_len > 0 ? heap_mdl[0] : '0;
    r.count = heap_len[6:0];
    if (r.status == mhpq_pkg::ST_FULL) n_full++;
    if (r.status == mhpq_pkg::ST_NOTFOUND) n_notfound++;
    return r;
  endfunction

  // one item through the handshake, with the given gap before it
  task automatic send_item(input logic [1:0] op, input logic signed [31:0] v,
                           input bit fixed, input heap_result_t want, input int gap);
    heap_result_t p;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_value <= v;
    do @(posedge clk); while (in_stall);
    p = heap_apply(op, v);
    if (fixed && p != want)
      $display("note: directed row %0d disagrees with prediction", n_sent);
    expected_q.push_back(fixed ? want : p);
    n_sent++;
  endtask

  function automatic logic signed [31:0] rand_val(input bit narrow);
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2, 3, 4: return narrow ? $signed($urandom_range(0, 15)) - 8 : $urandom;
      default: return narrow ? $signed($urandom_range(0, 63)) - 32 : $urandom;
    endcase
  endfunction

  function automatic heap_result_t mk(input logic [1:0] s, input logic signed [31:0] rm,
                                      input logic signed [31:0] tp, input int c);
    heap_result_t r;
    r.status = s;
    r.removed = rm;
    r.top = tp;
    r.count = c[6:0];
    return r;
  endfunction

  stim_row_t dir_tab[$];

  task automatic add_row(input logic [1:0] op, input logic signed [31:0] v,
                         input bit fixed, input heap_result_t r);
    stim_row_t s;
    s.op = op;
    s.val = v;
    s.fixed = fixed;
    s.res = r;
    dir_tab.push_back(s);
  endtask

  // driver
  initial begin
    int burst, gap, fill;
    logic [1:0] op;
    heap_len = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_row(mhpq_pkg::OP_POP, 0, 1, mk(mhpq_pkg::ST_EMPTY, 0, 0, 0));
    add_row(mhpq_pkg::OP_REMOVE, 5, 1, mk(mhpq_pkg::ST_EMPTY, 0, 0, 0));
    add_row(OP_NOP, -1, 1, mk(mhpq_pkg::ST_OK, 0, 0, 0));
    add_row(mhpq_pkg::OP_INSERT, 32'sh80000000, 1, mk(mhpq_pkg::ST_OK, 0, 32'sh80000000, 1));
    add_row(mhpq_pkg::OP_INSERT, 32'sh7fffffff, 1, mk(mhpq_pkg::ST_OK, 0, 32'sh7fffffff, 2));
    add_row(mhpq_pkg::OP_INSERT, -1, 1, mk(mhpq_pkg::ST_OK, 0, 32'sh7fffffff, 3));
    add_row(mhpq_pkg::OP_INSERT, -1, 0, '0);
    add_row(mhpq_pkg::OP_INSERT, 0, 0, '0);
    add_row(mhpq_pkg::OP_REMOVE, 12345, 0, '0);
    add_row(mhpq_pkg::OP_REMOVE, -1, 0, '0);
    add_row(mhpq_pkg::OP_REMOVE, 32'sh7fffffff, 0, '0);
    add_row(mhpq_pkg::OP_POP, 0, 0, '0);
    add_row(OP_NOP, 32'sh55555555, 0, '0);
    add_row(mhpq_pkg::OP_POP, 0, 0, '0);
    add_row(mhpq_pkg::OP_POP, 0, 0, '0);
    add_row(mhpq_pkg::OP_POP, 0, 1, mk(mhpq_pkg::ST_EMPTY, 0, 0, 0));
    foreach (dir_tab[i])
      send_item(dir_tab[i].op, dir_tab[i].val, dir_tab[i].fixed, dir_tab[i].res,
                $urandom_range(0, 3));

    // fill to capacity, overflow, then drain
    for (int i = 0; i < CAP + 3; i++)
      send_item(mhpq_pkg::OP_INSERT, rand_val(0), 0, '0, $urandom_range(0, 1));
    send_item(mhpq_pkg::OP_REMOVE, rand_val(0), 0, '0, 0);
    for (int i = 0; i < CAP + 2; i++)
      send_item(mhpq_pkg::OP_POP, $urandom, 0, '0, $urandom_range(0, 1));

    while (n_sent < 1300) begin
      burst = $urandom_range(1, 20);
      gap = $urandom_range(0, 4) == 0 ? 0 : $urandom_range(0, 6);
      fill = $urandom_range(0, 100);
      for (int b = 0; b < burst; b++) begin
        case ($urandom_range(0, 19))
          0: op = OP_NOP;
          1, 2, 3, 4, 5: op = mhpq_pkg::OP_POP;
          6, 7, 8, 9: op = mhpq_pkg::OP_REMOVE;
          default: op = mhpq_pkg::OP_INSERT;
        endcase
        if (fill < 30 && op == mhpq_pkg::OP_INSERT && $urandom_range(0, 1))
          op = mhpq_pkg::OP_POP;
        if (fill > 80 && op == mhpq_pkg::OP_POP) op = mhpq_pkg::OP_INSERT;
        if (op == mhpq_pkg::OP_REMOVE && heap_len > 0 && $urandom_range(0, 3) != 0)
          send_item(op, heap_mdl[$urandom_range(0, heap_len - 1)], 0, '0, 0);
        else
          send_item(op, rand_val(fill[0]), 0, '0, b == 0 ? gap : 0);
      end
    end
    in_valid <= 1'b0;

    wait (expected_q.size() == 0);
    repeat (120) @(posedge clk);
    $display("%0d items sent, %0d results checked; %0d full refusals, %0d failed searches",
             n_sent, n_checked, n_full, n_notfound);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("max_heap_priority_queue_top test passed");
    end else begin
      $display("max_heap_priority_queue_top test failed");
    end
    $finish;
  end

  // receiver stall pattern: quiet stretches and busy stretches
  int stall_mode = 0;
  always @(posedge clk) begin
    if (($urandom & 255) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ($urandom_range(0, 9) != 0);
    endcase
  end

  always @(posedge clk) begin
    heap_result_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $display("unexpected result");
        errors++;
      end else begin
        w = expected_q.pop_front();
        if (out_status !== w.status)
          report("status", 32'(out_status), 32'(w.status));
        if (out_removed_value !== w.removed) report("removed", out_removed_value, w.removed);
        if (out_top_value !== w.top) report("top", out_top_value, w.top);
        if (out_entry_count !== w.count)
          report("count", 32'(out_entry_count), 32'(w.count));
      end
      n_checked++;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("max_heap_priority_queue_top test failed");
      $finish;
    end
  end
endmodule
